// ===== rtl/uuld_pkg.sv =====
// ----------------------------------------------------------------------------
// uuld_pkg: shared types and constants of the uuencoded line decoder
// Field widths, the job record between front and back, sextet helpers.
// ----------------------------------------------------------------------------
package uuld_pkg;

	localparam int CHAR_W   = 8;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 6;
	localparam int SEXTET_W = 6;
	localparam int GROUP_W  = 18;
	localparam int WORD_W   = 24;
	localparam int NB_W     = 2;
	localparam int POS_W    = 2;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [COUNT_W-1:0]  MAX_LINE_RESET = 6'd45;
	localparam logic [SEXTET_W-1:0] SPACE_CODE     = 6'd32;
	localparam logic [1:0]          LAST_SEXTET    = 2'd3;
	localparam logic [NB_W-1:0]     MAX_GROUP_BYTES = 2'd3;

	// one entry of work: the bytes of a 24-bit word plus line status
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [NB_W-1:0]   nbytes;  // 0 means an empty line-end result
		logic              done;
		logic              bad;
	} job_t;

	// character to sextet, modulo 64 (backquote reads as zero)
	function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
		sextet_of = c[SEXTET_W-1:0] - SPACE_CODE;
	endfunction

	// bytes a group may still give: min(3, left)
	function automatic logic [NB_W-1:0] group_bytes(input logic [COUNT_W-1:0] left);
		if (left >= COUNT_W'(MAX_GROUP_BYTES))
			group_bytes = MAX_GROUP_BYTES;
		else
			group_bytes = left[NB_W-1:0];
	endfunction

endpackage

// ===== rtl/uuld_char_if.sv =====
// ----------------------------------------------------------------------------
// uuld_char_if: encoded character channel
// valid/ready handshake carrying one character and its line-end mark.
// ----------------------------------------------------------------------------
interface uuld_char_if;
	logic                        valid;
	logic                        ready;
	logic [uuld_pkg::CHAR_W-1:0] char_in;
	logic                        line_end;

	modport source (output valid, output char_in, output line_end, input ready);
	modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

// ===== rtl/uuld_byte_if.sv =====
// ----------------------------------------------------------------------------
// uuld_byte_if: decoded byte channel
// valid/ready handshake carrying one decoded byte and line status.
// ----------------------------------------------------------------------------
interface uuld_byte_if;
	logic                        valid;
	logic                        ready;
	logic [uuld_pkg::BYTE_W-1:0] byte_out;
	logic                        byte_valid;
	logic                        line_done;
	logic                        corrupt;

	modport source (output valid, output byte_out, output byte_valid,
		output line_done, output corrupt, input ready);
	modport sink   (input valid, input byte_out, input byte_valid,
		input line_done, input corrupt, output ready);
endinterface

// ===== rtl/uuld_front.sv =====
// ----------------------------------------------------------------------------
// uuld_front: character intake and group assembly
// Tracks the line state, packs sextets into groups and posts one job per
// character that yields results.
// ----------------------------------------------------------------------------
module uuld_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [uuld_pkg::COUNT_W-1:0] cfg_wdata,
	uuld_char_if.sink                    in_ch,
	input  logic                         q_full,
	output logic                         q_push,
	output uuld_pkg::job_t               q_job
);
	import uuld_pkg::*;

	logic                 expect_count_q;
	logic [COUNT_W-1:0]   bytes_left_q;
	logic [1:0]           sextet_idx_q;
	logic [GROUP_W-1:0]   group_q;
	logic                 line_bad_q;
	logic [COUNT_W-1:0]   max_bytes_q;

	logic                 expect_n;
	logic [COUNT_W-1:0]   left_n;
	logic [1:0]           idx_n;
	logic [GROUP_W-1:0]   group_n;
	logic                 bad_n;
	logic                 accept;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// next line state and the job this character produces
	always_comb begin
		logic [SEXTET_W-1:0] s;
		logic                bad_cur;
		s        = sextet_of(in_ch.char_in);
		expect_n = expect_count_q;
		left_n   = bytes_left_q;
		idx_n    = sextet_idx_q;
		group_n  = group_q;
		bad_n    = line_bad_q;
		q_job    = '0;

		if (expect_count_q) begin
			left_n   = s;
			bad_n    = (s > max_bytes_q);
			idx_n    = '0;
			group_n  = '0;
			expect_n = 1'b0;
		end else if (!line_bad_q && bytes_left_q != '0) begin
			if (sextet_idx_q != LAST_SEXTET) begin
				group_n = {group_q[GROUP_W-SEXTET_W-1:0], s};
				idx_n   = sextet_idx_q + 2'd1;
			end else begin
				q_job.word   = {group_q, s};
				q_job.nbytes = group_bytes(bytes_left_q);
				left_n       = bytes_left_q - COUNT_W'(q_job.nbytes);
				idx_n        = '0;
				group_n      = '0;
			end
		end
		bad_cur   = bad_n;
		q_job.bad = bad_cur;

		// line end: flush a partial group, zero padded, then rearm
		if (in_ch.line_end) begin
			if (!bad_cur && idx_n != '0 && left_n != '0) begin
				case (idx_n)
					2'd1:    q_job.word = {group_n[SEXTET_W-1:0], 18'd0};
					2'd2:    q_job.word = {group_n[2*SEXTET_W-1:0], 12'd0};
					default: q_job.word = {group_n, 6'd0};
				endcase
				q_job.nbytes = group_bytes(left_n);
			end
			q_job.done = 1'b1;
			expect_n   = 1'b1;
			left_n     = '0;
			idx_n      = '0;
			group_n    = '0;
			bad_n      = 1'b0;
		end
	end

	assign q_push = accept && (q_job.nbytes != '0 || in_ch.line_end);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_count_q <= 1'b1;
			bytes_left_q   <= '0;
			sextet_idx_q   <= '0;
			group_q        <= '0;
			line_bad_q     <= 1'b0;
		end else if (accept) begin
			expect_count_q <= expect_n;
			bytes_left_q   <= left_n;
			sextet_idx_q   <= idx_n;
			group_q        <= group_n;
			line_bad_q     <= bad_n;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_bytes_q <= MAX_LINE_RESET;
		else if (cfg_we)
			max_bytes_q <= cfg_wdata;
	end

	a_count_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		expect_count_q |-> (bytes_left_q == '0 && sextet_idx_q == '0 && !line_bad_q))
		else $error("count state not cleared");

	a_bad_line_silent: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_job.bad |-> q_job.nbytes == '0)
		else $error("corrupt line produced data");

endmodule

// ===== rtl/uuld_queue.sv =====
// ----------------------------------------------------------------------------
// uuld_queue: job queue between front and back
// Small register FIFO; the front stalls only when it is full.
// ----------------------------------------------------------------------------
module uuld_queue #(
	parameter int DEPTH = uuld_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uuld_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output uuld_pkg::job_t pop_job,
	output logic           empty
);
	import uuld_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ===== rtl/uuld_back.sv =====
// ----------------------------------------------------------------------------
// uuld_back: byte emitter
// Takes jobs from the queue and sends their bytes one transfer at a time
// through an output register.
// ----------------------------------------------------------------------------
module uuld_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  uuld_pkg::job_t q_job,
	output logic           q_pop,
	uuld_byte_if.source    out_ch
);
	import uuld_pkg::*;

	job_t              cur_q;
	logic              cur_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              byte_valid_q;
	logic              line_done_q;
	logic              corrupt_q;

	logic              slot_free;
	logic              emit;
	logic              last;
	logic [NB_W-1:0]   n_results;
	logic [BYTE_W-1:0] sel_byte;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign emit      = cur_valid_q && slot_free;
	assign n_results = (cur_q.nbytes == '0) ? NB_W'(1) : cur_q.nbytes;
	assign last      = (pos_q == n_results - 1'b1);
	assign q_pop     = !q_empty && (!cur_valid_q || (emit && last));

	// byte select, most significant first
	always_comb begin
		case (pos_q)
			2'd0:    sel_byte = cur_q.word[23:16];
			2'd1:    sel_byte = cur_q.word[15:8];
			default: sel_byte = cur_q.word[7:0];
		endcase
	end

	// current job tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			pos_q       <= '0;
		end else if (emit) begin
			pos_q <= pos_q + 1'b1;
			if (last)
				cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_job;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (slot_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_valid_q <= (cur_q.nbytes != '0);
			byte_q       <= (cur_q.nbytes != '0) ? sel_byte : '0;
			line_done_q  <= cur_q.done && last;
			corrupt_q    <= cur_q.bad;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.byte_out   = byte_q;
	assign out_ch.byte_valid = byte_valid_q;
	assign out_ch.line_done  = line_done_q;
	assign out_ch.corrupt    = corrupt_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> pos_q < n_results)
		else $error("byte position past job end");

	a_empty_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !byte_valid_q |-> line_done_q)
		else $error("empty result without line end");

endmodule

// ===== rtl/uu_line_decoder_top.sv =====
// ----------------------------------------------------------------------------
// uu_line_decoder_top: uuencoded body line decoder
// Front end, job queue and byte emitter wired together.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one encoded character per transfer with line_end set on the
//   last character of a line; the first character of each line is the count.
//   out_ch gives one result per transfer: a decoded byte, or on a line that
//   yields no data an empty result (byte_valid low) that closes the line.
//   line_done marks the last result of a line, corrupt a line whose count is
//   above max_line_bytes (cfg_we / cfg_wdata, write only while idle).
//   Results pass a queue slot, the current-job register and the output
//   register. Throughput, unless stalled: one character per cycle on in_ch
//   and one result per cycle on out_ch; a full group posts up to three
//   results, which the emitter drains while the queue keeps taking characters.
//   A stall on out_ch fills the job queue (QUEUE_DEPTH entries); in_ch.ready
//   drops only when the queue is full.
//   Reset clears the line state (next character is a count), empties the
//   queue and sets max_line_bytes to 45.
// ----------------------------------------------------------------------------
module uu_line_decoder_top #(
	parameter int QUEUE_DEPTH = uuld_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [uuld_pkg::COUNT_W-1:0] cfg_wdata,
	uuld_char_if.sink                    in_ch,
	uuld_byte_if.source                  out_ch
);
	import uuld_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t pop_job;

	uuld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	uuld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	uuld_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (pop_job),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: uuencoded line decoder, self-checking
// A scoreboard predicts the decoded bytes and line status for every character
// transfer and checks each output transfer in order. Directed lines cover the
// corner cases; random lines at several byte limits and random handshake
// idling cover the rest, including one long output hold.
// ----------------------------------------------------------------------------

// one character of a body line as driven on the input channel
typedef struct {
	bit [7:0] ch;
	bit       eol;
} char_item_t;

// one decoded result as seen on the output channel
typedef struct {
	bit [7:0] data;
	bit       has_byte;
	bit       eol;
	bit       bad;
} decoded_t;

class uu_byte_scoreboard;
	bit [5:0]  max_count;
	bit        awaiting_count;
	bit [5:0]  left;
	bit [1:0]  nsext;
	bit [17:0] held;
	bit        bad;
	decoded_t  expected_bytes[$];
	int        mismatches;
	int        checked;
	int        lines;
	int        bad_lines;

	function new();
		max_count      = uuld_pkg::MAX_LINE_RESET;
		awaiting_count = 1'b1;
		left           = '0;
		nsext          = '0;
		held           = '0;
		bad            = 1'b0;
		mismatches     = 0;
		checked        = 0;
		lines          = 0;
		bad_lines      = 0;
	endfunction

	function void set_max(bit [5:0] v);
		max_count = v;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function bit [5:0] sextet(bit [7:0] c);
		return c[5:0] - 6'd32;
	endfunction

	// queue up to min(3, left) bytes of a 24-bit word, MSB first
	function int push_word(bit [23:0] word);
		decoded_t r;
		int       n;
		n = 0;
		for (int i = 0; i < 3 && left > 0; i++) begin
			r.data     = word[23 - 8 * i -: 8];
			r.has_byte = 1'b1;
			r.eol      = 1'b0;
			r.bad      = bad;
			expected_bytes.push_back(r);
			left--;
			n++;
		end
		return n;
	endfunction

	// predict the results of one accepted character
	function void note_char(bit [7:0] c, bit eol);
		int        k;
		bit [5:0]  s;
		bit [23:0] word;
		decoded_t  r;
		k = 0;
		if (awaiting_count) begin
			left           = sextet(c);
			bad            = (left > max_count);
			nsext          = '0;
			held           = '0;
			awaiting_count = 1'b0;
		end else if (!bad && left > 0) begin
			s = sextet(c);
			if (nsext < 3) begin
				held = {held[11:0], s};
				nsext++;
			end else begin
				k     = push_word({held, s});
				nsext = '0;
				held  = '0;
			end
		end

		if (eol) begin
			// partial group: missing sextets read as zero
			if (!bad && nsext > 0 && left > 0) begin
				word = {6'd0, held} << (6 * (4 - nsext));
				k += push_word(word);
			end
			if (k > 0) begin
				expected_bytes[expected_bytes.size() - 1].eol = 1'b1;
			end else begin
				r.data     = '0;
				r.has_byte = 1'b0;
				r.eol      = 1'b1;
				r.bad      = bad;
				expected_bytes.push_back(r);
			end
			lines++;
			if (bad) begin
				bad_lines++;
			end
			awaiting_count = 1'b1;
			left           = '0;
			nsext          = '0;
			held           = '0;
			bad            = 1'b0;
		end
	endfunction

	function void check_result(logic [7:0] data, logic has_byte, logic eol, logic bad_flag);
		decoded_t e;
		checked++;
		if (expected_bytes.size() == 0) begin
			if (mismatches < 10) begin
				$display("ERROR: result with nothing expected: byte=%h valid=%b done=%b corrupt=%b",
					data, has_byte, eol, bad_flag);
			end
			mismatches++;
		end else begin
			e = expected_bytes.pop_front();
			if (data !== e.data || has_byte !== e.has_byte || eol !== e.eol ||
					bad_flag !== e.bad) begin
				if (mismatches < 10) begin
					$display("ERROR: result %0d: expected byte=%h valid=%b done=%b corrupt=%b",
						checked, e.data, e.has_byte, e.eol, e.bad);
					$display("       actual            byte=%h valid=%b done=%b corrupt=%b",
						data, has_byte, eol, bad_flag);
				end
				mismatches++;
			end
		end
	endfunction
endclass

module testbench;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int CYCLE_LIMIT   = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [uuld_pkg::COUNT_W-1:0] cfg_wdata;

	uuld_char_if char_ch();
	uuld_byte_if byte_ch();

	uu_line_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (char_ch),
		.out_ch    (byte_ch)
	);

	uu_byte_scoreboard sb = new();
	char_item_t        stim_q[$];
	int                chars_taken = 0;
	int                cycle_count = 0;
	int                settings_used = 1;
	bit                idle_on = 1'b1;
	bit                hold_request = 1'b0;

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// transfer monitor: predict on input, check on output
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_ch.valid && char_ch.ready) begin
				sb.note_char(char_ch.char_in, char_ch.line_end);
				chars_taken++;
			end
			if (byte_ch.valid && byte_ch.ready) begin
				sb.check_result(byte_ch.byte_out, byte_ch.byte_valid,
					byte_ch.line_done, byte_ch.corrupt);
			end
		end
	end

	// output side: random stalls, plus one long hold on request
	initial begin
		byte_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				byte_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				byte_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				byte_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				byte_ch.ready <= 1'b1;
			end else begin
				byte_ch.ready <= 1'b1;
			end
		end
	end

	task automatic queue_char(input bit [7:0] c, input bit eol);
		char_item_t item;
		item.ch  = c;
		item.eol = eol;
		stim_q.push_back(item);
	endtask

	// one random line: mostly well formed, some short, long, over-limit or noise
	task automatic add_line();
		int kind;
		int lim;
		int n;
		int full;
		int nchars;
		lim  = sb.max_count;
		kind = $urandom_range(0, 99);
		if (kind < 12 && lim < 63) begin
			n = $urandom_range(lim + 1, 63);
		end else if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, lim);
		end else begin
			n = $urandom_range(0, (lim < 9) ? lim : 9);
		end
		full = 4 * ((n + 2) / 3);
		if (kind < 70) begin
			nchars = full;
		end else if (kind < 80) begin
			nchars = $urandom_range(0, full);
		end else if (kind < 90) begin
			nchars = full + $urandom_range(1, 6);
		end else begin
			nchars = -1;
		end

		if (nchars < 0) begin
			// noise: any byte values, count char included
			nchars = $urandom_range(0, 10);
			queue_char(8'($urandom_range(0, 255)), 1'b0);
			for (int i = 0; i < nchars; i++) begin
				queue_char(8'($urandom_range(0, 255)), 1'b0);
			end
		end else begin
			// count char, aliased through the upper bits now and then
			queue_char(8'(32 + n + 64 * (($urandom_range(0, 3) == 0) ?
				$urandom_range(1, 3) : 0)), 1'b0);
			for (int i = 0; i < nchars; i++) begin
				queue_char(8'($urandom_range(32, 96)), 1'b0);
			end
		end
		stim_q[stim_q.size() - 1].eol = 1'b1;
	endtask

	// send the queued characters, waiting on each transfer
	task automatic drive_stimulus();
		char_item_t item;
		int         taken;
		while (stim_q.size() > 0) begin
			item  = stim_q.pop_front();
			taken = chars_taken;
			char_ch.valid    <= 1'b1;
			char_ch.char_in  <= item.ch;
			char_ch.line_end <= item.eol;
			do @(negedge clk); while (chars_taken == taken);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				char_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
		end
		char_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int target);
		while (stim_q.size() < target) begin
			add_line();
		end
		drive_stimulus();
		wait_drained();
	endtask

	task automatic write_max_bytes(input bit [5:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_max(v);
		settings_used++;
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		char_ch.valid    <= 1'b0;
		char_ch.char_in  <= '0;
		char_ch.line_end <= 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty line: count char carries the line end
		queue_char(8'h20, 1'b1);
		// three all-ones bytes
		queue_char(8'h23, 1'b0);
		queue_char(8'h5F, 1'b0);
		queue_char(8'h5F, 1'b0);
		queue_char(8'h5F, 1'b0);
		queue_char(8'h5F, 1'b1);
		// short line ending mid group, backquote and high-bit chars
		queue_char(8'h29, 1'b0);
		queue_char(8'h60, 1'b0);
		queue_char(8'h20, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(8'h80, 1'b0);
		queue_char(8'hFF, 1'b0);
		queue_char(8'h5F, 1'b1);
		// count above the default limit
		queue_char(8'h4E, 1'b0);
		queue_char(8'h41, 1'b0);
		queue_char(8'h42, 1'b0);
		queue_char(8'h43, 1'b1);
		// count reached, later data ignored
		queue_char(8'h21, 1'b0);
		queue_char(8'h30, 1'b0);
		queue_char(8'h31, 1'b0);
		queue_char(8'h32, 1'b0);
		queue_char(8'h33, 1'b0);
		queue_char(8'h34, 1'b0);
		queue_char(8'h35, 1'b1);
		run_phase(124);

		// widest limit, with the output held off for a long stretch
		write_max_bytes(6'd63);
		hold_request = 1'b1;
		run_phase(100);

		write_max_bytes(6'd1);
		run_phase(80);

		write_max_bytes(6'($urandom_range(2, 62)));
		run_phase(80);

		// back to the default limit, no idling at all
		idle_on = 1'b0;
		write_max_bytes(uuld_pkg::MAX_LINE_RESET);
		run_phase(80);

		$display("Covered %0d lines (%0d over the limit), %0d results checked, %0d mismatches",
			sb.lines, sb.bad_lines, sb.checked, sb.mismatches);
		$display("across %0d byte-limit settings incl. 1 and 63, random idling and a long hold",
			settings_used);
		if (sb.pending() > 0) begin
			$display("ERROR: %0d expected results never arrived", sb.pending());
		end
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/uuld_pkg.sv
rtl/uuld_char_if.sv
rtl/uuld_byte_if.sv
rtl/uuld_front.sv
rtl/uuld_queue.sv
rtl/uuld_back.sv
rtl/uu_line_decoder_top.sv
dv/testbench.sv
